// ----- sv/tlpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpq_pkg - shared types for the three-level priority queue
// Operation, status and class codes, field widths, store control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int COUNT_W     = 5;
  localparam int TOTAL_W     = 6;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_HIGH   = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LOW    = 2'd2
  } class_t;

  // control from the pointer logic to the ring store
  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    logic   bypass;
    logic   front_valid;
    class_t wr_cls;
    class_t rd_cls;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- sv/three_level_priority_queue.sv -----
// ----------------------------------------------------------------------------
// three_level_priority_queue - strict priority queue, three classes
// Input words carry op (push, pop, peek), value and priority_req. Each
// accepted word yields one result word with status, the front word and
// class after the operation, and the total and per-class counts.
// The result is registered and valid in the cycle after the input is accepted.
// One word per cycle while in_stall is low; the pointer update, front
// selection and ring read complete between input and result register.
// Each class is a ring of CLASS_DEPTH entries; a push into a full class is
// dropped with status full, a pop on an empty queue returns status empty.
// Reset empties all classes; ring contents are not cleared and need no
// clearing pass. While a result waits and out_stall is high, in_stall is
// raised and the result register holds its word.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue #(
  parameter int CLASS_DEPTH = 16,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [VALUE_BITS-1:0]  in_value,
  input  wire logic [1:0]                    in_priority_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_front_valid,
  output logic signed [VALUE_BITS-1:0]       out_front_value,
  output logic [1:0]                         out_front_priority,
  output logic [tlpq_pkg::TOTAL_W-1:0]       out_total_count,
  output logic [tlpq_pkg::COUNT_W-1:0]       out_count_high,
  output logic [tlpq_pkg::COUNT_W-1:0]       out_count_medium,
  output logic [tlpq_pkg::COUNT_W-1:0]       out_count_low
);
  import tlpq_pkg::*;

  localparam int PTR_W = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
  localparam int SUM_W = CNT_W + 2;

  logic                              accept;
  store_ctl_t                        ctl;
  logic [PTR_W-1:0]                  wr_ptr;
  logic [PTR_W-1:0]                  rd_ptr;
  status_t                           status;
  class_t                            front_cls;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt_nxt;
  logic [SUM_W-1:0]                  total;
  logic [VALUE_BITS-1:0]             rd_data;

  logic                              out_valid_r;
  status_t                           status_r;
  logic                              front_valid_r;
  class_t                            front_cls_r;
  logic [TOTAL_W-1:0]                total_r;
  logic [COUNT_W-1:0]                cnt_high_r;
  logic [COUNT_W-1:0]                cnt_medium_r;
  logic [COUNT_W-1:0]                cnt_low_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  tlpq_ctrl #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .cls_req   (in_priority_req),
    .ctl       (ctl),
    .wr_ptr    (wr_ptr),
    .rd_ptr    (rd_ptr),
    .status    (status),
    .front_cls (front_cls),
    .cnt_nxt   (cnt_nxt)
  );

  tlpq_store #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .PTR_W       (PTR_W),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .ctl      (ctl),
    .wr_ptr   (wr_ptr),
    .rd_ptr   (rd_ptr),
    .wr_value (in_value),
    .rd_data  (rd_data)
  );

  assign total = SUM_W'(cnt_nxt[CLS_HIGH]) + SUM_W'(cnt_nxt[CLS_MEDIUM])
               + SUM_W'(cnt_nxt[CLS_LOW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status;
      front_valid_r <= ctl.front_valid;
      front_cls_r   <= front_cls;
      total_r       <= TOTAL_W'(total);
      cnt_high_r    <= COUNT_W'(cnt_nxt[CLS_HIGH]);
      cnt_medium_r  <= COUNT_W'(cnt_nxt[CLS_MEDIUM]);
      cnt_low_r     <= COUNT_W'(cnt_nxt[CLS_LOW]);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_front_valid    = front_valid_r;
  assign out_front_value    = rd_data;
  assign out_front_priority = front_cls_r;
  assign out_total_count    = total_r;
  assign out_count_high     = cnt_high_r;
  assign out_count_medium   = cnt_medium_r;
  assign out_count_low      = cnt_low_r;

endmodule

`default_nettype wire

// ----- sv/tlpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpq_ctrl - pointer and occupancy control
// Holds per-class head/tail pointers and counts, decodes each word and
// picks the store write slot and the front read slot after the update.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl #(
  parameter int CLASS_DEPTH = 16,
  parameter int PTR_W       = 4,
  parameter int CNT_W       = 5
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   accept,
  input  wire logic [1:0]                             op,
  input  wire logic [1:0]                             cls_req,
  output tlpq_pkg::store_ctl_t                        ctl,
  output logic [PTR_W-1:0]                            wr_ptr,
  output logic [PTR_W-1:0]                            rd_ptr,
  output tlpq_pkg::status_t                           status,
  output tlpq_pkg::class_t                            front_cls,
  output logic [tlpq_pkg::NUM_CLASSES-1:0][CNT_W-1:0] cnt_nxt
);
  import tlpq_pkg::*;

  logic [NUM_CLASSES-1:0][PTR_W-1:0] head_r, head_nxt;
  logic [NUM_CLASSES-1:0][PTR_W-1:0] tail_r, tail_nxt;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt_r;

  class_t cls;
  class_t top_cur;
  class_t top_nxt;
  logic   any_cur;
  logic   any_nxt;
  logic   push_ok;
  logic   pop_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    cls = (cls_req > 2'(CLS_LOW)) ? CLS_LOW : class_t'(cls_req);

    any_cur = 1'b1;
    priority if (cnt_r[CLS_HIGH] != '0) begin
      top_cur = CLS_HIGH;
    end else if (cnt_r[CLS_MEDIUM] != '0) begin
      top_cur = CLS_MEDIUM;
    end else if (cnt_r[CLS_LOW] != '0) begin
      top_cur = CLS_LOW;
    end else begin
      top_cur = CLS_HIGH;
      any_cur = 1'b0;
    end

    push_ok = 1'b0;
    pop_ok  = 1'b0;
    status  = ST_DONE;
    unique case (op)
      OP_PUSH: begin
        if (cnt_r[cls] == CNT_W'(CLASS_DEPTH)) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (any_cur) begin
          pop_ok = 1'b1;
        end else begin
          status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase

    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      tail_nxt[cls] = ptr_inc(tail_r[cls]);
      cnt_nxt[cls]  = cnt_r[cls] + 1'b1;
    end
    if (pop_ok) begin
      head_nxt[top_cur] = ptr_inc(head_r[top_cur]);
      cnt_nxt[top_cur]  = cnt_r[top_cur] - 1'b1;
    end

    any_nxt = 1'b1;
    priority if (cnt_nxt[CLS_HIGH] != '0) begin
      top_nxt = CLS_HIGH;
    end else if (cnt_nxt[CLS_MEDIUM] != '0) begin
      top_nxt = CLS_MEDIUM;
    end else if (cnt_nxt[CLS_LOW] != '0) begin
      top_nxt = CLS_LOW;
    end else begin
      top_nxt = CLS_HIGH;
      any_nxt = 1'b0;
    end

    front_cls       = top_nxt;
    wr_ptr          = tail_r[cls];
    rd_ptr          = head_nxt[top_nxt];
    ctl.wr_en       = accept && push_ok;
    ctl.rd_en       = accept;
    // pushed word lands at the front when its class was empty and no higher class holds words
    ctl.bypass      = push_ok && (cls == top_nxt) && (cnt_r[cls] == '0);
    ctl.front_valid = any_nxt;
    ctl.wr_cls      = cls;
    ctl.rd_cls      = top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tlpq_store.sv -----
// ----------------------------------------------------------------------------
// tlpq_store - class ring storage
// One write and one registered read per cycle, on accepted operations only;
// the read register then holds the front word, or zero if the queue is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_store #(
  parameter int CLASS_DEPTH = 16,
  parameter int PTR_W       = 4,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                   clk,
  input  wire tlpq_pkg::store_ctl_t   ctl,
  input  wire logic [PTR_W-1:0]       wr_ptr,
  input  wire logic [PTR_W-1:0]       rd_ptr,
  input  wire logic [VALUE_BITS-1:0]  wr_value,
  output logic [VALUE_BITS-1:0]       rd_data
);
  import tlpq_pkg::*;

  logic [VALUE_BITS-1:0] ring_mem [NUM_CLASSES][CLASS_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ring_mem[ctl.wr_cls][wr_ptr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      priority if (!ctl.front_valid) begin
        rd_data_r <= '0;
      end else if (ctl.bypass) begin
        rd_data_r <= wr_value;
      end else begin
        rd_data_r <= ring_mem[ctl.rd_cls][rd_ptr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
